### rtl/core/glcd_pkg.sv
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared constants and types for the glyph to LCD byte stream core.
// ----------------------------------------------------------------------------
package glcd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE   = 2'd1;

  localparam logic [7:0] START_COLUMN_RESET = 8'd4;
  localparam logic [2:0] START_PAGE_RESET   = 3'd0;

  localparam logic [7:0] FIRST_CODE  = 8'd65;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam int unsigned CMD_STEPS  = 3;

  localparam int unsigned K_W = 4;

  typedef struct packed {
    logic       valid;
    logic       is_data;
    logic       bad;
    logic       last;
    logic [7:0] cmd;
  } glcd_issue_t;

  typedef struct packed {
    logic           en;
    logic [7:0]     glyph;
    logic [K_W-1:0] k;
  } glcd_rom_req_t;

endpackage

### rtl/core/glcd_font_rom.sv
// ----------------------------------------------------------------------------
// glcd_font_rom
// Font ROM, nine bytes per glyph, registered synchronous read.
// ----------------------------------------------------------------------------
module glcd_font_rom (
  input  logic                   clk,
  input  glcd_pkg::glcd_rom_req_t req,
  output logic [7:0]             q
);
  import glcd_pkg::*;

  localparam int unsigned FONT_GLYPHS = 26;
  localparam int unsigned ROM_STRIDE  = 9;
  localparam int unsigned FONT_DEPTH  = FONT_GLYPHS * ROM_STRIDE;

  localparam logic [7:0] FONT [FONT_DEPTH] = '{
    8'h07, 8'h00, 8'hC0, 8'hF8, 8'h3F, 8'h23, 8'h3F, 8'hF8, 8'hC0,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h89, 8'h89, 8'hFF, 8'h76, 8'h00,
    8'h07, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h42, 8'h00,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h81, 8'hC3, 8'h7E, 8'h3C, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h89, 8'h89, 8'h81, 8'h00, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00,
    8'h07, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h91, 8'hF3, 8'hF2, 8'h00,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h08, 8'h08, 8'h08, 8'hFF, 8'hFF,
    8'h03, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h06, 8'h00, 8'h40, 8'hC0, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h18, 8'h7E, 8'hE3, 8'h81, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h0E, 8'h18, 8'h0E, 8'hFF, 8'hFF,
    8'h07, 8'h00, 8'hFF, 8'hFE, 8'h0C, 8'h30, 8'hFF, 8'hFF, 8'h00,
    8'h08, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h7E, 8'h3C,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h1F, 8'h0E, 8'h00, 8'h00,
    8'h08, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h7E, 8'h3C,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h31, 8'h7F, 8'hCE, 8'h80,
    8'h06, 8'h00, 8'h46, 8'hCF, 8'h99, 8'hF3, 8'h62, 8'h00, 8'h00,
    8'h07, 8'h00, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h00,
    8'h07, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h80, 8'hFF, 8'h7F, 8'h00,
    8'h08, 8'h00, 8'h01, 8'h0F, 8'h7C, 8'hE0, 8'h7C, 8'h0F, 8'h01,
    8'h08, 8'h00, 8'h01, 8'h0F, 8'h7E, 8'hF0, 8'h3E, 8'h07, 8'h3E,
    8'h08, 8'h00, 8'h81, 8'hC3, 8'h7E, 8'h18, 8'h7E, 8'hC3, 8'h81,
    8'h08, 8'h00, 8'h01, 8'h07, 8'h0E, 8'hF8, 8'hF8, 8'h0E, 8'h07,
    8'h07, 8'h00, 8'h81, 8'hE1, 8'hB9, 8'h9D, 8'h87, 8'h81, 8'h00
  };

  logic [8:0] addr;
  logic       hit;

  assign addr = 9'(req.glyph[4:0]) * 9'(ROM_STRIDE) + 9'(req.k);
  assign hit  = (req.glyph < 8'(FONT_GLYPHS)) && (addr < 9'(FONT_DEPTH));

  always_ff @(posedge clk) begin
    if (req.en) begin
      q <= hit ? FONT[addr[7:0]] : 8'h00;
    end
  end

endmodule

### rtl/core/glcd_seq.sv
// ----------------------------------------------------------------------------
// glcd_seq
// Character sequencer: holds the cursor, takes one character and walks its
// command and glyph bytes, one byte per cycle while the output advances.
// ----------------------------------------------------------------------------
module glcd_seq #(
  parameter int unsigned GLYPH_COUNT = 26,
  parameter int unsigned GLYPH_BYTES = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              char_code,
  input  logic                    string_start,
  input  logic [7:0]              start_column,
  input  logic [2:0]              start_page,
  input  logic                    advance,
  output glcd_pkg::glcd_issue_t   iss,
  output glcd_pkg::glcd_rom_req_t rom_req
);
  import glcd_pkg::*;

  localparam int unsigned TOTAL_STEPS = CMD_STEPS + GLYPH_BYTES;
  localparam int unsigned STEP_W      = $clog2(TOTAL_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_STEPS - 1);
  localparam logic [STEP_W-1:0] STEP_COL_HI = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_COL_LO = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_PAGE   = STEP_W'(2);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [7:0]        glyph;
  logic              bad;
  logic [7:0]        col;
  logic [7:0]        cursor;

  logic              at_last;
  logic              accept;
  logic [7:0]        col_eff;
  logic [8:0]        rel_code;
  logic              good;
  logic [4:0]        k_wide;
  logic [7:0]        cmd;

  assign at_last  = bad || (step == LAST_STEP);
  assign in_stall = busy && !(advance && at_last);
  assign accept   = in_valid && !in_stall;

  assign col_eff  = string_start ? start_column : cursor;
  assign rel_code = {1'b0, char_code} - {1'b0, FIRST_CODE};
  assign good     = rel_code < 9'(GLYPH_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cursor <= START_COLUMN_RESET;
    end else begin
      if (accept) begin
        busy   <= 1'b1;
        cursor <= good ? col_eff + 8'(GLYPH_BYTES) : col_eff;
      end else if (busy && advance && at_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step  <= '0;
      glyph <= rel_code[7:0];
      bad   <= !good;
      col   <= col_eff;
    end else if (busy && advance) begin
      step <= step + STEP_W'(1);
    end
  end

  always_comb begin
    unique case (step)
      STEP_COL_HI: cmd = CMD_COL_HI | {4'h0, col[7:4]};
      STEP_COL_LO: cmd = {4'h0, col[3:0]};
      STEP_PAGE:   cmd = CMD_PAGE | {5'b0, start_page};
      default:     cmd = 8'h00;
    endcase
  end

  assign k_wide = 5'(step) - 5'(CMD_STEPS);

  assign iss.valid   = busy;
  assign iss.is_data = !bad && (5'(step) >= 5'(CMD_STEPS));
  assign iss.bad     = bad;
  assign iss.last    = at_last;
  assign iss.cmd     = bad ? 8'h00 : cmd;

  assign rom_req.en    = advance;
  assign rom_req.glyph = glyph;
  assign rom_req.k     = k_wide[K_W-1:0];

endmodule

### rtl/core/glyph_to_lcd_byte_stream_core.sv
// ----------------------------------------------------------------------------
// glyph_to_lcd_byte_stream_core
// Turns characters into LCD controller command and glyph data bytes.
//
// Input channel (in_valid / in_stall): one character per transfer, with
// string_start to reload the cursor from start_column first.
// Output channel (out_valid / out_stall): one controller byte per transfer.
// A letter gives three cursor commands then GLYPH_BYTES font bytes, last set
// on the final one; any other code gives one byte with bad_char and last set.
// Configuration (cfg_valid / cfg_ready): index 0 start_column, 1 start_page;
// cfg_ready is always high, write only while the core is idle.
// The first byte passes the sequencer's step register and then the output
// register before it is valid at the output. The sequencer issues one byte
// per cycle while the output does not stall, into the font ROM read and the
// output register, and takes the next character while issuing the last byte
// of the current one.
// Reset: cursor and start_column return to 4, start_page to 0, no output.
// Out stall: the output register and ROM read hold, the sequencer freezes
// and in_stall stays high until the character's last byte is issued.
// ----------------------------------------------------------------------------
module glyph_to_lcd_byte_stream_core #(
  parameter int unsigned GLYPH_COUNT = 26,
  parameter int unsigned GLYPH_BYTES = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     char_code,
  input  logic                           string_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     lcd_byte,
  output logic                           is_data,
  output logic                           bad_char,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [glcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import glcd_pkg::*;

  logic [7:0]    start_column;
  logic [2:0]    start_page;
  logic          advance;
  glcd_issue_t   iss;
  glcd_rom_req_t rom_req;
  logic [7:0]    rom_q;
  logic [7:0]    cmd_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_column <= START_COLUMN_RESET;
      start_page   <= START_PAGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_COLUMN: start_column <= cfg_data;
        CFG_START_PAGE:   start_page   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || !out_stall;

  glcd_seq #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .GLYPH_BYTES(GLYPH_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .string_start (string_start),
    .start_column (start_column),
    .start_page   (start_page),
    .advance      (advance),
    .iss          (iss),
    .rom_req      (rom_req)
  );

  glcd_font_rom u_rom (
    .clk (clk),
    .req (rom_req),
    .q   (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= iss.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_data  <= iss.is_data;
      bad_char <= iss.bad;
      last     <= iss.last;
      cmd_byte <= iss.cmd;
    end
  end

  assign lcd_byte = is_data ? rom_q : cmd_byte;

`ifndef SYNTHESIS
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> last && !is_data && (lcd_byte == 8'h00))
    else $error("bad character byte malformed");

  a_accept_at_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && iss.valid |-> iss.last && advance)
    else $error("character taken before previous one fully issued");

  a_cmd_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !(out_valid && is_data))
    else $error("data byte directly after final byte of a character");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph to LCD byte stream core.
//
// Characters go in one transfer at a time. A scoreboard model follows the
// cursor, the start column and the page, and queues the expected command and
// font bytes for each character. Every output transfer is checked against the
// oldest queued byte. Directed tests cover reset values, bad codes and column
// extremes. Random strings follow under several register settings, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
  import glcd_pkg::*;

  localparam int GLYPH_COUNT = 26;
  localparam int GLYPH_BYTES = 9;
  localparam int ROM_GLYPHS  = 26;
  localparam int ROM_STRIDE  = 9;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       bad_char;
    logic       last;
  } lcd_xfer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           char_code = 8'h00;
  logic                 string_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           lcd_byte;
  logic                 is_data;
  logic                 bad_char;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START_COLUMN;
  logic [7:0]           cfg_data = 8'h00;

  logic [7:0] font_rom [0:ROM_GLYPHS*ROM_STRIDE-1] = '{
    8'h07, 8'h00, 8'hC0, 8'hF8, 8'h3F, 8'h23, 8'h3F, 8'hF8, 8'hC0,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h89, 8'h89, 8'hFF, 8'h76, 8'h00,
    8'h07, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h42, 8'h00,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h81, 8'hC3, 8'h7E, 8'h3C, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h89, 8'h89, 8'h81, 8'h00, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00,
    8'h07, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h91, 8'hF3, 8'hF2, 8'h00,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h08, 8'h08, 8'h08, 8'hFF, 8'hFF,
    8'h03, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h06, 8'h00, 8'h40, 8'hC0, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00,
    8'h07, 8'h00, 8'hFF, 8'hFF, 8'h18, 8'h7E, 8'hE3, 8'h81, 8'h00,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h0E, 8'h18, 8'h0E, 8'hFF, 8'hFF,
    8'h07, 8'h00, 8'hFF, 8'hFE, 8'h0C, 8'h30, 8'hFF, 8'hFF, 8'h00,
    8'h08, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h7E, 8'h3C,
    8'h06, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h1F, 8'h0E, 8'h00, 8'h00,
    8'h08, 8'h00, 8'h3C, 8'h7E, 8'hC3, 8'h81, 8'hC3, 8'h7E, 8'h3C,
    8'h08, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h31, 8'h7F, 8'hCE, 8'h80,
    8'h06, 8'h00, 8'h46, 8'hCF, 8'h99, 8'hF3, 8'h62, 8'h00, 8'h00,
    8'h07, 8'h00, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h00,
    8'h07, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h80, 8'hFF, 8'h7F, 8'h00,
    8'h08, 8'h00, 8'h01, 8'h0F, 8'h7C, 8'hE0, 8'h7C, 8'h0F, 8'h01,
    8'h08, 8'h00, 8'h01, 8'h0F, 8'h7E, 8'hF0, 8'h3E, 8'h07, 8'h3E,
    8'h08, 8'h00, 8'h81, 8'hC3, 8'h7E, 8'h18, 8'h7E, 8'hC3, 8'h81,
    8'h08, 8'h00, 8'h01, 8'h07, 8'h0E, 8'hF8, 8'hF8, 8'h0E, 8'h07,
    8'h07, 8'h00, 8'h81, 8'hE1, 8'hB9, 8'h9D, 8'h87, 8'h81, 8'h00
  };

  // scoreboard state
  logic [7:0] start_col  = START_COLUMN_RESET;
  logic [2:0] start_pg   = START_PAGE_RESET;
  logic [7:0] cursor_col = START_COLUMN_RESET;
  lcd_xfer_t  bytes_due [$];
  lcd_xfer_t  want_xfer;

  bit in_gaps_on = 1'b0;
  bit stall_on   = 1'b0;
  int stall_left = 0;

  int err_count  = 0;
  int n_checked  = 0;
  int n_letters  = 0;
  int n_bad      = 0;
  int n_restarts = 0;
  int n_wraps    = 0;
  int n_settings = 0;

  glyph_to_lcd_byte_stream_core #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .GLYPH_BYTES(GLYPH_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .string_start (string_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lcd_byte     (lcd_byte),
    .is_data      (is_data),
    .bad_char     (bad_char),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #6_000_000;
    $display("[glyph_to_lcd_byte_stream_core] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      return 8'($urandom_range(65, 64 + GLYPH_COUNT));
    end else if (r < 94) begin
      return 8'($urandom_range(0, 64));
    end else begin
      return 8'($urandom_range(65 + GLYPH_COUNT, 255));
    end
  endfunction

  task automatic predict_lcd_bytes(input logic [7:0] code, input logic restart);
    int         glyph;
    logic [7:0] col;
    logic [7:0] rom_byte;
    if (restart) begin
      cursor_col = start_col;
      n_restarts++;
    end
    glyph = int'(code) - int'(FIRST_CODE);
    if (glyph < 0 || glyph >= GLYPH_COUNT) begin
      bytes_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      n_bad++;
    end else begin
      col = cursor_col;
      bytes_due.push_back('{CMD_COL_HI | {4'h0, col[7:4]}, 1'b0, 1'b0, 1'b0});
      bytes_due.push_back('{{4'h0, col[3:0]}, 1'b0, 1'b0, 1'b0});
      bytes_due.push_back('{CMD_PAGE | {5'd0, start_pg}, 1'b0, 1'b0, 1'b0});
      for (int k = 0; k < GLYPH_BYTES; k++) begin
        rom_byte = (glyph < ROM_GLYPHS && k < ROM_STRIDE) ?
                   font_rom[glyph*ROM_STRIDE + k] : 8'h00;
        bytes_due.push_back('{rom_byte, 1'b1, 1'b0, k == GLYPH_BYTES - 1});
      end
      if (int'(col) + GLYPH_BYTES > 255) begin
        n_wraps++;
      end
      cursor_col = col + 8'(GLYPH_BYTES);
      n_letters++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("%0t mismatch on %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  task automatic send_char(input logic [7:0] code, input logic restart);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= code;
    string_start <= restart;
    do @(posedge clk); while (in_stall);
    predict_lcd_bytes(code, restart);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_COLUMN) begin
      start_col = data;
    end else if (idx == CFG_START_PAGE) begin
      start_pg = data[2:0];
    end
    n_settings++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_on) begin
      stall_left = pick_gap();
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (bytes_due.size() == 0) begin
        report_mismatch("unexpected transfer", lcd_byte, 0);
      end else begin
        want_xfer = bytes_due.pop_front();
        if (lcd_byte !== want_xfer.lcd_byte) begin
          report_mismatch("lcd_byte", lcd_byte, want_xfer.lcd_byte);
        end
        if (is_data !== want_xfer.is_data) begin
          report_mismatch("is_data", is_data, want_xfer.is_data);
        end
        if (bad_char !== want_xfer.bad_char) begin
          report_mismatch("bad_char", bad_char, want_xfer.bad_char);
        end
        if (last !== want_xfer.last) begin
          report_mismatch("last", last, want_xfer.last);
        end
        n_checked++;
      end
    end
  end

  task automatic test_after_reset();
    send_char("A", 1'b0);
    send_char("Z", 1'b0);
    send_char("B", 1'b1);
  endtask

  task automatic test_bad_codes();
    hold_until_drained();
    write_reg(CFG_START_COLUMN, 8'd100);
    send_char("A", 1'b0);
    send_char(8'd0, 1'b1);
    send_char(8'd91, 1'b0);
    send_char("M", 1'b0);
    send_char(8'd255, 1'b0);
    send_char(8'd64, 1'b1);
    send_char("Y", 1'b0);
    send_char(8'h80, 1'b0);
    send_char("a", 1'b0);
  endtask

  task automatic test_column_extremes();
    hold_until_drained();
    write_reg(CFG_START_COLUMN, 8'd255);
    write_reg(CFG_START_PAGE, 8'hFF);
    send_char("C", 1'b1);
    send_char("D", 1'b0);
    hold_until_drained();
    write_reg(CFG_START_COLUMN, 8'd0);
    write_reg(CFG_START_PAGE, 8'h08);
    send_char("E", 1'b1);
    send_char("F", 1'b0);
    hold_until_drained();
    write_reg(CFG_START_COLUMN, 8'd131);
    write_reg(CFG_START_PAGE, 8'h07);
    send_char("W", 1'b1);
    send_char("X", 1'b0);
  endtask

  task automatic test_random_strings(input int phases, input int per_phase);
    int         left_in_string;
    logic       restart;
    logic [7:0] col;
    for (int p = 0; p < phases; p++) begin
      hold_until_drained();
      in_gaps_on = (p % 4 == 1) || (p % 4 == 3);
      stall_on   = (p % 4 >= 2);
      case ($urandom_range(0, 3))
        0: col = 8'd0;
        1: col = 8'd131;
        2: col = 8'd255;
        default: col = 8'($urandom_range(0, 255));
      endcase
      write_reg(CFG_START_COLUMN, col);
      write_reg(CFG_START_PAGE, 8'($urandom_range(0, 255)));
      left_in_string = 0;
      for (int i = 0; i < per_phase; i++) begin
        // hold off mid-phase until the output side is empty
        if (i == per_phase / 2) begin
          hold_until_drained();
        end
        if (left_in_string == 0) begin
          restart = 1'b1;
          left_in_string = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                                          $urandom_range(1, 8);
        end else begin
          restart = ($urandom_range(0, 29) == 0);
        end
        left_in_string--;
        send_char(pick_code(), restart);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_bad_codes();
    test_column_extremes();
    test_random_strings(8, 50);
    hold_until_drained();
    repeat (12) @(posedge clk);
    $display("covered %0d letters, %0d bad codes, %0d string restarts, %0d column wraps",
             n_letters, n_bad, n_restarts, n_wraps);
    $display("checked %0d output bytes across %0d register writes", n_checked, n_settings);
    if (err_count == 0) begin
      $display("[glyph_to_lcd_byte_stream_core] OK");
    end else begin
      $display("[glyph_to_lcd_byte_stream_core] ERROR");
    end
    $finish;
  end

endmodule
